@@ design/csvd_pkg.sv @@
`timescale 1ns / 1ps
package csvd_pkg;
   localparam int MaxPositions = 256;
   localparam int PosWidth = $clog2(MaxPositions);
   localparam int CountWidth = PosWidth + 1;
   localparam logic [31:0] CostCeiling = 32'd65280;
   localparam logic [2:0] ColorInvalid = 3'd4;
   localparam int WordLimit = 32;
   localparam int WordWidth = 5;
   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_LENGTH = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_FETCH = 5'b00010,
      ST_CALC  = 5'b00100,
      ST_TRACE = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;
endpackage

@@ design/color_space_viterbi_decode.sv @@
`timescale 1ns / 1ps
// Channel   Ports                                           Handshake
// req       req_ref_base req_quality req_color_code req_last start / busy
// rsp       rsp_status rsp_word_index rsp_bases              rsp_valid, one cycle
//           rsp_base_count rsp_final_res
// An item is accepted, then the back pointer row of the previous position is read
// (a registered read), then the four add-compare-select units run and the row of
// the current position is written. After the last item the trace reads the row of
// each position, then writes the base and steps back; then the packer reads and
// takes each base in turn. Synchronous reset clears control state only. The
// receiver cannot stall; busy is set by sequencing.
module color_space_viterbi_decode (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [2:0]                 req_ref_base,
   input  logic [6:0]                 req_quality,
   input  logic [2:0]                 req_color_code,
   input  logic                       req_last,
   output logic                       rsp_valid,
   output logic                       rsp_status,
   output logic [4:0]                 rsp_word_index,
   output logic [15:0]                rsp_bases,
   output logic [3:0]                 rsp_base_count,
   output logic                       rsp_final_res
);
   import csvd_pkg::*;

   state_type state_ff, state_in;
   logic [31:0] cost_ff [4];
   logic [31:0] cost_in [4];
   logic [6:0]  prev_q_ff, prev_q_in;
   logic [2:0]  prev_c_ff, prev_c_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic        ovf_ff, ovf_in;
   logic [2:0]  rb_ff, rb_in;
   logic [6:0]  q_ff, q_in;
   logic [2:0]  cc_ff, cc_in;
   logic        last_ff, last_in;

   // back pointer memory: one row of four 2-bit pointers per position
   logic [7:0] bp_mem [MaxPositions];
   logic [7:0] bp_rd_ff;
   logic       bp_we;
   logic [PosWidth-1:0] bp_waddr, bp_raddr;
   logic [7:0] bp_wdata;

   // decoded base memory
   logic [1:0] dec_mem [MaxPositions];
   logic [1:0] dec_rd_ff;
   logic       dec_we;
   logic [PosWidth-1:0] dec_waddr, dec_raddr;
   logic [1:0] dec_wdata;

   // trace and emit counters
   logic [CountWidth-1:0] tpos_ff, tpos_in;
   logic [1:0]  tstate_ff, tstate_in;
   logic        trd_ff, trd_in;
   logic [CountWidth-1:0] epos_ff, epos_in;
   logic [3:0]  eslot_ff, eslot_in;
   logic [15:0] pack_ff, pack_in;
   logic [4:0]  widx_ff, widx_in;
   logic        erd_ff, erd_in;
   logic        ov_ff, ov_in;
   logic        os_ff, os_in;
   logic [4:0]  ow_ff, ow_in;
   logic [15:0] ob_ff, ob_in;
   logic [3:0]  oc_ff, oc_in;
   logic        of_ff, of_in;

   always_ff @(posedge clock) begin
      if (bp_we) bp_mem[bp_waddr] <= bp_wdata;
      bp_rd_ff <= bp_mem[bp_raddr];
      if (dec_we) dec_mem[dec_waddr] <= dec_wdata;
      dec_rd_ff <= dec_mem[dec_raddr];
   end

   // add-compare-select for one position
   logic [31:0] acs_cost [4];
   logic [1:0]  acs_bp [4];
   always_comb begin
      logic [31:0] best, qh, cand;
      logic [1:0]  bp, pp, refc;
      logic        pm, cm;
      for (int j = 0; j < 4; j++) begin
         best = CostCeiling;
         bp = 2'd0;
         for (int k = 0; k < 4; k++) begin
            refc = 2'(k) ^ 2'(j);
            cm = (cc_ff == {1'b0, refc});
            pp = bp_rd_ff[2*k +: 2];
            pm = (count_ff >= CountWidth'(2)) && (prev_c_ff != ColorInvalid)
                 && (prev_c_ff == {1'b0, 2'(k) ^ pp});
            qh = 32'd0;
            if (pm) qh = cm ? 32'(q_ff) + 32'(prev_q_ff) : 32'(prev_q_ff) - 32'(q_ff);
            else if (cm) qh = 32'(q_ff) - 32'(prev_q_ff);
            cand = cost_ff[k] + ((rb_ff == 3'(j)) ? 32'd0 : qh) + (cm ? 32'd0 : 32'(q_ff));
            if (cand < best) begin
               best = cand;
               bp = 2'(k);
            end
         end
         acs_cost[j] = best;
         acs_bp[j] = bp;
      end
   end

   // cheapest final state
   logic [1:0] best_s;
   always_comb begin
      best_s = 2'd0;
      for (int i = 1; i < 4; i++)
         if (cost_ff[i] < cost_ff[best_s]) best_s = 2'(i);
   end

   always_comb begin
      state_in = state_ff;
      for (int j = 0; j < 4; j++) cost_in[j] = cost_ff[j];
      prev_q_in = prev_q_ff; prev_c_in = prev_c_ff;
      count_in = count_ff; ovf_in = ovf_ff;
      rb_in = rb_ff; q_in = q_ff; cc_in = cc_ff; last_in = last_ff;
      tpos_in = tpos_ff; tstate_in = tstate_ff; trd_in = 1'b0;
      epos_in = epos_ff; eslot_in = eslot_ff; pack_in = pack_ff;
      widx_in = widx_ff; erd_in = 1'b0;
      ov_in = 1'b0; os_in = os_ff; ow_in = ow_ff; ob_in = ob_ff;
      oc_in = oc_ff; of_in = of_ff;
      bp_we = 1'b0; bp_waddr = count_ff[PosWidth-1:0]; bp_wdata = 8'd0;
      bp_raddr = count_ff[PosWidth-1:0] - PosWidth'(1);
      dec_we = 1'b0; dec_waddr = tpos_ff[PosWidth-1:0]; dec_wdata = tstate_ff;
      dec_raddr = epos_ff[PosWidth-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rb_in = req_ref_base; q_in = req_quality;
               cc_in = req_color_code; last_in = req_last;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            // advance the trellis one position, or note overflow
            if (!ovf_ff) begin
               if (count_ff < CountWidth'(MaxPositions)) begin
                  bp_we = 1'b1;
                  if (count_ff == '0) begin
                     for (int j = 0; j < 4; j++)
                        cost_in[j] = (rb_ff == 3'(j)) ? 32'd0 : 32'(q_ff);
                  end else begin
                     for (int j = 0; j < 4; j++) begin
                        cost_in[j] = acs_cost[j];
                        bp_wdata[2*j +: 2] = acs_bp[j];
                     end
                  end
                  prev_c_in = (count_ff == '0) ? ColorInvalid : cc_ff;
                  prev_q_in = q_ff;
                  count_in = count_ff + CountWidth'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            state_in = ST_IDLE;
            if (last_ff) begin
               if (ovf_in || count_in < CountWidth'(2)) begin
                  ov_in = 1'b1; os_in = STATUS_LENGTH; ow_in = '0; ob_in = '0;
                  oc_in = '0; of_in = 1'b1;
                  for (int j = 0; j < 4; j++) cost_in[j] = 32'd0;
                  prev_q_in = '0; prev_c_in = ColorInvalid; count_in = '0;
                  ovf_in = 1'b0;
               end else begin
                  tpos_in = count_in - CountWidth'(1);
                  state_in = ST_TRACE;
                  trd_in = 1'b0;
               end
            end
         end
         ST_TRACE: begin
            // read the row of one position, then write its base and step back
            bp_raddr = tpos_ff[PosWidth-1:0];
            if (!trd_ff) begin
               if (tpos_ff == count_ff - CountWidth'(1)) tstate_in = best_s;
               trd_in = 1'b1;
            end else begin
               dec_we = 1'b1;
               if (tpos_ff == '0) begin
                  state_in = ST_EMIT;
                  epos_in = '0; eslot_in = '0; pack_in = '0; widx_in = '0;
               end else begin
                  tstate_in = bp_rd_ff[2*tstate_ff +: 2];
                  tpos_in = tpos_ff - CountWidth'(1);
               end
            end
            if (!trd_ff) dec_wdata = tstate_in;
         end
         ST_EMIT: begin
            // pack the bases one at a time (read each, then take it)
            if (!erd_ff) begin
               erd_in = 1'b1;
            end else begin
               pack_in = pack_ff | (16'(dec_rd_ff) << (2 * eslot_ff));
               eslot_in = eslot_ff + 4'd1;
               epos_in = epos_ff + CountWidth'(1);
               if (eslot_in == 4'd8 || epos_in == count_ff) begin
                  ov_in = 1'b1; os_in = STATUS_OK; ow_in = widx_ff;
                  ob_in = pack_in; oc_in = eslot_in;
                  of_in = (epos_in == count_ff) || (widx_ff == 5'(WordLimit - 1));
                  widx_in = widx_ff + 5'd1; eslot_in = '0; pack_in = '0;
                  if (of_in) begin
                     state_in = ST_IDLE;
                     for (int j = 0; j < 4; j++) cost_in[j] = 32'd0;
                     prev_q_in = '0; prev_c_in = ColorInvalid; count_in = '0;
                     ovf_in = 1'b0;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // hold the trace state across the pointer read
   logic [1:0] tcur;
   assign tcur = tstate_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int j = 0; j < 4; j++) cost_ff[j] <= 32'd0;
         prev_q_ff <= '0; prev_c_ff <= ColorInvalid; count_ff <= '0; ovf_ff <= 1'b0;
         ov_ff <= 1'b0; trd_ff <= 1'b0; erd_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         for (int j = 0; j < 4; j++) cost_ff[j] <= cost_in[j];
         prev_q_ff <= prev_q_in; prev_c_ff <= prev_c_in;
         count_ff <= count_in; ovf_ff <= ovf_in;
         ov_ff <= ov_in; trd_ff <= trd_in; erd_ff <= erd_in;
      end
      rb_ff <= rb_in; q_ff <= q_in; cc_ff <= cc_in; last_ff <= last_in;
      tpos_ff <= tpos_in; tstate_ff <= tcur;
      epos_ff <= epos_in; eslot_ff <= eslot_in; pack_ff <= pack_in; widx_ff <= widx_in;
      os_ff <= os_in; ow_ff <= ow_in; ob_ff <= ob_in; oc_ff <= oc_in; of_ff <= of_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = ov_ff;
   assign rsp_status = os_ff;
   assign rsp_word_index = ow_ff;
   assign rsp_bases = ob_ff;
   assign rsp_base_count = oc_ff;
   assign rsp_final_res = of_ff;

   a_cnt: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(MaxPositions)) else $error("position count overflow");
   a_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK |-> rsp_base_count != 4'd0 && rsp_base_count <= 4'd8)
      else $error("bad base count");
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_LENGTH |-> rsp_final_res) else $error("error not final");
   a_fin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_final_res |-> count_ff == '0) else $error("read state not cleared");
endmodule
